// ===== sv/uartrb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uartrb_pkg
// Shared types and constants for the UART register file with board responder.
// ----------------------------------------------------------------------------
package uartrb_pkg;

  // Receive FIFO geometry.
  localparam int RX_DEPTH = 16;
  localparam int RX_PTR_W = $clog2(RX_DEPTH);
  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

  // Opcodes of an input word.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register byte offsets.
  localparam logic [11:0] REG_DATA = 12'h000;
  localparam logic [11:0] REG_IER  = 12'h002;
  localparam logic [11:0] REG_IIR  = 12'h004;
  localparam logic [11:0] REG_LCR  = 12'h006;
  localparam logic [11:0] REG_MCR  = 12'h008;
  localparam logic [11:0] REG_LSR  = 12'h00A;
  localparam logic [11:0] REG_SCR  = 12'h00E;

  // Configuration register indexes.
  localparam int                 CFG_IDX_W      = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

  // Responder modes.
  localparam logic [1:0] MODE_NONE      = 2'd0;
  localparam logic [1:0] MODE_HANDSHAKE = 2'd1;
  localparam logic [1:0] MODE_STREAM    = 2'd2;

  localparam logic [15:0] THRESHOLD_RESET = 16'd240;

  // Register file constants.
  localparam int          DLAB_BIT  = 7;
  localparam logic [15:0] LSR_BASE  = 16'h0060;
  localparam logic [15:0] IIR_VALUE = 16'h0001;
  localparam logic [7:0]  FCR_MASK  = 8'hC9;

  // Handshake command bytes and status codes.
  localparam logic [7:0] CMD_RESET   = 8'h20;
  localparam logic [7:0] CMD_QUERY   = 8'h1F;
  localparam logic [7:0] CMD_CALIB_A = 8'h14;
  localparam logic [7:0] CMD_CALIB_B = 8'h1A;
  localparam logic [7:0] CMD_DONE_A  = 8'h11;
  localparam logic [7:0] CMD_DONE_B  = 8'h03;
  localparam logic [7:0] CMD_ZERO    = 8'h00;
  localparam logic [7:0] ST_IDLE     = 8'h00;
  localparam logic [7:0] ST_READY    = 8'h01;
  localparam logic [7:0] ST_BUSY     = 8'h80;
  localparam logic [2:0] CALIB_MAX   = 3'd5;
  localparam logic [2:0] CALIB_BUSY_LIMIT = 3'd4;

  // Streamer refill bytes: "C01".
  localparam logic [7:0] STREAM_B0 = 8'h43;
  localparam logic [7:0] STREAM_B1 = 8'h30;
  localparam logic [7:0] STREAM_B2 = 8'h31;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] reg_offset;
    logic [15:0] write_data;
    logic [15:0] tick_cycles;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        irq_pulse;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] threshold;
  } cfg_t;

  // Commands from the control logic to the receive FIFO.
  typedef struct packed {
    logic            pop;
    logic            clear;
    logic [1:0]      push_n;
    logic [2:0][7:0] push_byte;
  } fifo_cmd_t;

  typedef struct packed {
    logic [RX_CNT_W-1:0] count;
    logic [7:0]          head_byte;
  } fifo_stat_t;

endpackage
`default_nettype wire

// ===== sv/uartrb_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uartrb_fifo
// Receive FIFO: one pop or up to three pushes per word, plus a clear.
// ----------------------------------------------------------------------------
module uartrb_fifo (
  input  wire                     clk,
  input  wire                     rst_n,
  input  uartrb_pkg::fifo_cmd_t   cmd,
  output uartrb_pkg::fifo_stat_t  stat
);

  localparam int SUM_W = uartrb_pkg::RX_CNT_W + 1;

  logic [7:0]                    mem_r [uartrb_pkg::RX_DEPTH];
  logic [uartrb_pkg::RX_PTR_W-1:0] head_r, head_nxt;
  logic [uartrb_pkg::RX_CNT_W-1:0] count_r, count_nxt;

  logic [2:0]                      push_ok;
  logic [2:0][uartrb_pkg::RX_PTR_W-1:0] slot;
  logic [uartrb_pkg::RX_CNT_W-1:0] push_acc;
  logic [SUM_W-1:0]                sum;

  // A push lands only while there is room; the slot wraps with a single subtract.
  always_comb begin
    push_acc = '0;
    sum      = '0;
    for (int k = 0; k < 3; k++) begin
      push_ok[k] = (2'(k) < cmd.push_n) &&
                   ((SUM_W'(count_r) + SUM_W'(k)) < SUM_W'(uartrb_pkg::RX_DEPTH));
      sum = SUM_W'(head_r) + SUM_W'(count_r) + SUM_W'(k);
      if (sum >= SUM_W'(uartrb_pkg::RX_DEPTH)) begin
        sum = sum - SUM_W'(uartrb_pkg::RX_DEPTH);
      end
      slot[k] = sum[uartrb_pkg::RX_PTR_W-1:0];
      push_acc = push_acc + uartrb_pkg::RX_CNT_W'(push_ok[k]);
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.pop && count_r != '0) begin
      if (head_r == uartrb_pkg::RX_PTR_W'(uartrb_pkg::RX_DEPTH - 1)) begin
        head_nxt = '0;
      end else begin
        head_nxt = head_r + 1'b1;
      end
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r + push_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (push_ok[k]) begin
        mem_r[slot[k]] <= cmd.push_byte[k];
      end
    end
  end

  assign stat.count     = count_r;
  assign stat.head_byte = mem_r[head_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= uartrb_pkg::RX_CNT_W'(uartrb_pkg::RX_DEPTH))
    else $error("receive FIFO count above depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (count_r == '0) && (head_r == '0))
    else $error("receive FIFO not empty after clear");

endmodule
`default_nettype wire

// ===== sv/uartrb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uartrb_ctrl
// Register file, handshake responder and tick streamer for one word.
// ----------------------------------------------------------------------------
module uartrb_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     fire,
  input  uartrb_pkg::in_item_t    item,
  input  uartrb_pkg::cfg_t        cfg,
  input  uartrb_pkg::fifo_stat_t  fifo_stat,
  output uartrb_pkg::fifo_cmd_t   fifo_cmd,
  output uartrb_pkg::out_item_t   result
);

  logic [15:0] ier_r, ier_nxt;
  logic [15:0] lcr_r, lcr_nxt;
  logic [15:0] mcr_r, mcr_nxt;
  logic [15:0] scr_r, scr_nxt;
  logic [15:0] dll_r, dll_nxt;
  logic [15:0] dlh_r, dlh_nxt;
  logic [7:0]  fcr_r, fcr_nxt;
  logic        parity_r, parity_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [2:0]  calib_r, calib_nxt;
  logic        done_r, done_nxt;
  logic [31:0] accum_r, accum_nxt;

  logic                  dlab;
  logic                  fifo_has_data;
  logic [7:0]            cur;
  logic [7:0]            status;
  logic [32:0]           acc_sum;
  logic [31:0]           acc_sat;
  uartrb_pkg::fifo_cmd_t cmd;

  assign dlab          = lcr_r[uartrb_pkg::DLAB_BIT];
  assign fifo_has_data = (fifo_stat.count != '0);
  assign cur           = item.write_data[7:0];
  assign acc_sum       = {1'b0, accum_r} + {17'b0, item.tick_cycles};
  assign acc_sat       = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];

  always_comb begin
    ier_nxt    = ier_r;
    lcr_nxt    = lcr_r;
    mcr_nxt    = mcr_r;
    scr_nxt    = scr_r;
    dll_nxt    = dll_r;
    dlh_nxt    = dlh_r;
    fcr_nxt    = fcr_r;
    parity_nxt = parity_r;
    prev_nxt   = prev_r;
    calib_nxt  = calib_r;
    done_nxt   = done_r;
    accum_nxt  = accum_r;
    status     = uartrb_pkg::ST_IDLE;
    cmd        = '0;
    result     = '0;

    case (item.opcode)
      uartrb_pkg::OP_READ: begin
        unique case (item.reg_offset)
          uartrb_pkg::REG_DATA: begin
            if (dlab) begin
              result.read_data = dll_r;
            end else if (fifo_has_data) begin
              result.read_data = {8'h00, fifo_stat.head_byte};
              cmd.pop          = 1'b1;
            end
          end
          uartrb_pkg::REG_IER: result.read_data = dlab ? dlh_r : ier_r;
          uartrb_pkg::REG_IIR: result.read_data = uartrb_pkg::IIR_VALUE;
          uartrb_pkg::REG_LCR: result.read_data = lcr_r;
          uartrb_pkg::REG_MCR: result.read_data = mcr_r;
          uartrb_pkg::REG_LSR:
            result.read_data = uartrb_pkg::LSR_BASE | {15'b0, fifo_has_data};
          uartrb_pkg::REG_SCR: result.read_data = scr_r;
          default: result.read_data = '0;
        endcase
      end

      uartrb_pkg::OP_WRITE: begin
        unique case (item.reg_offset)
          uartrb_pkg::REG_DATA: begin
            if (dlab) begin
              dll_nxt = item.write_data;
            end else if (cfg.mode == uartrb_pkg::MODE_HANDSHAKE) begin
              // The first byte of a pair is only remembered.
              parity_nxt = ~parity_r;
              prev_nxt   = cur;
              if (parity_r) begin
                if (prev_r == uartrb_pkg::CMD_RESET && cur == uartrb_pkg::CMD_ZERO) begin
                  done_nxt  = 1'b0;
                  calib_nxt = '0;
                end
                if (!done_nxt) begin
                  if (prev_r == uartrb_pkg::CMD_RESET || prev_r == uartrb_pkg::CMD_QUERY) begin
                    status = uartrb_pkg::ST_READY;
                  end else if (prev_r == uartrb_pkg::CMD_CALIB_A &&
                               cur == uartrb_pkg::CMD_CALIB_B) begin
                    if (calib_nxt < uartrb_pkg::CALIB_MAX) begin
                      calib_nxt = calib_nxt + 1'b1;
                    end
                    status = (calib_nxt > uartrb_pkg::CALIB_BUSY_LIMIT) ?
                             uartrb_pkg::ST_IDLE : uartrb_pkg::ST_BUSY;
                  end
                  if (prev_r == uartrb_pkg::CMD_DONE_A && cur == uartrb_pkg::CMD_DONE_B) begin
                    done_nxt = 1'b1;
                  end
                end
                cmd.push_n       = 2'd2;
                cmd.push_byte[0] = status;
                cmd.push_byte[1] = uartrb_pkg::ST_IDLE;
                result.irq_pulse = 1'b1;
              end
            end
          end
          uartrb_pkg::REG_IER: begin
            if (dlab) begin
              dlh_nxt = item.write_data;
            end else begin
              ier_nxt = item.write_data;
            end
          end
          uartrb_pkg::REG_IIR: fcr_nxt = item.write_data[7:0] & uartrb_pkg::FCR_MASK;
          uartrb_pkg::REG_LCR: lcr_nxt = item.write_data;
          uartrb_pkg::REG_MCR: mcr_nxt = item.write_data;
          uartrb_pkg::REG_SCR: scr_nxt = item.write_data;
          default: ;
        endcase
      end

      uartrb_pkg::OP_TICK: begin
        if (cfg.mode == uartrb_pkg::MODE_HANDSHAKE) begin
          // Ticks are ignored while the handshake responder runs.
        end else if (cfg.mode != uartrb_pkg::MODE_STREAM) begin
          cmd.clear = 1'b1;
        end else if (ier_r[0]) begin
          if (acc_sat >= {16'b0, cfg.threshold}) begin
            accum_nxt        = '0;
            result.irq_pulse = 1'b1;
            if (!fifo_has_data) begin
              cmd.push_n       = 2'd3;
              cmd.push_byte[0] = uartrb_pkg::STREAM_B0;
              cmd.push_byte[1] = uartrb_pkg::STREAM_B1;
              cmd.push_byte[2] = uartrb_pkg::STREAM_B2;
            end
          end else begin
            accum_nxt = acc_sat;
          end
        end
      end

      default: ;
    endcase
  end

  assign fifo_cmd = fire ? cmd : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ier_r    <= '0;
      lcr_r    <= '0;
      mcr_r    <= '0;
      scr_r    <= '0;
      dll_r    <= '0;
      dlh_r    <= '0;
      fcr_r    <= '0;
      parity_r <= 1'b0;
      prev_r   <= '0;
      calib_r  <= '0;
      done_r   <= 1'b0;
      accum_r  <= '0;
    end else if (fire) begin
      ier_r    <= ier_nxt;
      lcr_r    <= lcr_nxt;
      mcr_r    <= mcr_nxt;
      scr_r    <= scr_nxt;
      dll_r    <= dll_nxt;
      dlh_r    <= dlh_nxt;
      fcr_r    <= fcr_nxt;
      parity_r <= parity_nxt;
      prev_r   <= prev_nxt;
      calib_r  <= calib_nxt;
      done_r   <= done_nxt;
      accum_r  <= accum_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/uart_regs_with_board_responder_top.sv =====
// A word accepted at the input is held in the input register, passes through the register file
// when the result register is free, and is then registered onto the result port.
// Throughput: one word per cycle without stalls, set by the single register-file pass.
// While a finished result waits to be taken, the input register holds one more word
// and then the input stalls until the result port is free again.
// Reset (rst_n, synchronous, active low) clears the register file, the responder state,
// the FIFO pointers and both pipeline valids; mode returns to 0 and threshold to 240.
`default_nettype none
// ----------------------------------------------------------------------------
// uart_regs_with_board_responder_top
// 16550-style register file with a board responder feeding the receive FIFO.
// ----------------------------------------------------------------------------
module uart_regs_with_board_responder_top (
  input  wire                                clk,
  input  wire                                rst_n,
  // Input channel.
  input  wire                                in_valid,
  output logic                               in_ready,
  input  uartrb_pkg::in_item_t               in_item,
  // Result channel.
  output logic                               out_valid,
  input  wire                                out_ready,
  output uartrb_pkg::out_item_t              out_item,
  // Configuration write port.
  input  wire                                cfg_we,
  input  wire [uartrb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [15:0]                         cfg_wdata
);

  // Pipeline: an input register, then one combinational pass through the
  // register file that updates all state, then the result register.
  logic                   in_valid_r;
  uartrb_pkg::in_item_t   in_item_r;
  logic                   out_valid_r;
  uartrb_pkg::out_item_t  out_item_r;
  logic                   advance;

  uartrb_pkg::cfg_t       cfg_r;
  uartrb_pkg::fifo_cmd_t  fifo_cmd;
  uartrb_pkg::fifo_stat_t fifo_stat;
  uartrb_pkg::out_item_t  result;

  // A word moves into the result register when that register is empty or is
  // being emptied in the same cycle; state updates only on that move.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  // Configuration registers; the user must write them only while the block is idle, which it does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= uartrb_pkg::MODE_NONE;
      cfg_r.threshold <= uartrb_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uartrb_pkg::CFG_MODE:      cfg_r.mode      <= cfg_wdata[1:0];
        uartrb_pkg::CFG_THRESHOLD: cfg_r.threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  uartrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (in_item_r),
    .cfg       (cfg_r),
    .fifo_stat (fifo_stat),
    .fifo_cmd  (fifo_cmd),
    .result    (result)
  );

  uartrb_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (fifo_cmd),
    .stat  (fifo_stat)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A waiting result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_item_r))
    else $error("pending result changed or dropped");

  // Every word that moves on must show up as a valid result.
  a_advance_valid: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced word produced no result");

endmodule
`default_nettype wire

// ===== verif/tb_uart_regs_with_board_responder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_regs_with_board_responder_top
// Self-checking testbench for the UART register file with board responder.
// A directed opening pass is followed by random register traffic in several
// responder modes and thresholds. Each accepted word is run through an
// in-bench model, and every result word is compared field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_uart_regs_with_board_responder_top;

  // Codes that the package does not name.
  localparam logic [1:0]  OP_NONE       = 2'd3;
  localparam logic [1:0]  MODE_NONE_ALT = 2'd3;
  localparam logic [11:0] REG_MSR       = 12'h00C;

  // The watchdog ends the run when the count of cycles without any handshake reaches this limit.
  localparam int WATCHDOG_LIMIT = 4000;
  // One long receiver hold-off is used to back the pipeline up into the input.
  localparam int HOLD_CYCLES    = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  uartrb_pkg::in_item_t  in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  uartrb_pkg::out_item_t out_item;
  logic                            cfg_we = 1'b0;
  logic [uartrb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                     cfg_wdata = '0;

  // Words waiting to be offered, and results predicted but not yet seen.
  uartrb_pkg::in_item_t  access_queue[$];
  uartrb_pkg::out_item_t expected_replies[$];

  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  logic in_fire = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_seen = 1'b0;
  int   hold_left = 0;
  int   idle_cycles = 0;
  int   error_count = 0;

  // Model state. It is set to its reset values once here, since reset is only
  // applied at the start of the run.
  logic [1:0]  mode_q = uartrb_pkg::MODE_NONE;
  logic [15:0] thresh_q = uartrb_pkg::THRESHOLD_RESET;
  logic [15:0] ier_q = '0;
  logic [15:0] lcr_q = '0;
  logic [15:0] mcr_q = '0;
  logic [15:0] scr_q = '0;
  logic [15:0] dll_q = '0;
  logic [15:0] dlh_q = '0;
  logic [7:0]  fcr_q = '0;
  logic [7:0]  rx_mem [uartrb_pkg::RX_DEPTH];
  int          rx_head = 0;
  int          rx_count = 0;
  logic        tx_parity = 1'b0;
  logic [7:0]  prev_tx = '0;
  int          calib_cnt = 0;
  logic        hs_done = 1'b0;
  logic [31:0] accum = '0;

  uart_regs_with_board_responder_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // A byte pushed into a full receive FIFO is lost.
  function automatic void rx_push(logic [7:0] b);
    if (rx_count < uartrb_pkg::RX_DEPTH) begin
      rx_mem[uartrb_pkg::RX_PTR_W'((rx_head + rx_count) % uartrb_pkg::RX_DEPTH)] = b;
      rx_count++;
    end
  endfunction

  // Appends a word to the list of words waiting to be offered.
  function automatic void queue_word(uartrb_pkg::in_item_t w);
    access_queue = {access_queue, w};
  endfunction

  // Computes the result of one register access or tick and advances the model.
  function automatic uartrb_pkg::out_item_t predict_register_access(
      uartrb_pkg::in_item_t w);
    uartrb_pkg::out_item_t r;
    logic        dlab;
    logic [7:0]  cur;
    logic [7:0]  status;
    logic [32:0] sum;
    r = '0;
    dlab = lcr_q[uartrb_pkg::DLAB_BIT];
    cur = w.write_data[7:0];
    status = uartrb_pkg::ST_IDLE;
    case (w.opcode)
      uartrb_pkg::OP_READ: begin
        case (w.reg_offset)
          uartrb_pkg::REG_DATA: begin
            // An empty FIFO reads as zero and leaves the pointers alone.
            if (dlab) begin
              r.read_data = dll_q;
            end else if (rx_count != 0) begin
              r.read_data = {8'h00, rx_mem[uartrb_pkg::RX_PTR_W'(rx_head)]};
              rx_head = (rx_head + 1) % uartrb_pkg::RX_DEPTH;
              rx_count--;
            end
          end
          uartrb_pkg::REG_IER: r.read_data = dlab ? dlh_q : ier_q;
          uartrb_pkg::REG_IIR: r.read_data = uartrb_pkg::IIR_VALUE;
          uartrb_pkg::REG_LCR: r.read_data = lcr_q;
          uartrb_pkg::REG_MCR: r.read_data = mcr_q;
          uartrb_pkg::REG_LSR:
            r.read_data = uartrb_pkg::LSR_BASE | {15'd0, (rx_count != 0)};
          uartrb_pkg::REG_SCR: r.read_data = scr_q;
          default: r.read_data = '0;
        endcase
      end
      uartrb_pkg::OP_WRITE: begin
        case (w.reg_offset)
          uartrb_pkg::REG_DATA: begin
            if (dlab) begin
              dll_q = w.write_data;
            end else if (mode_q == uartrb_pkg::MODE_HANDSHAKE) begin
              // Command bytes come in pairs; only the second one is answered.
              tx_parity = ~tx_parity;
              if (!tx_parity) begin
                if (prev_tx == uartrb_pkg::CMD_RESET && cur == uartrb_pkg::CMD_ZERO) begin
                  hs_done = 1'b0;
                  calib_cnt = 0;
                end
                if (!hs_done) begin
                  if (prev_tx == uartrb_pkg::CMD_RESET ||
                      prev_tx == uartrb_pkg::CMD_QUERY) begin
                    status = uartrb_pkg::ST_READY;
                  end else if (prev_tx == uartrb_pkg::CMD_CALIB_A &&
                               cur == uartrb_pkg::CMD_CALIB_B) begin
                    if (calib_cnt < uartrb_pkg::CALIB_MAX) calib_cnt++;
                    status = (calib_cnt > uartrb_pkg::CALIB_BUSY_LIMIT) ?
                             uartrb_pkg::ST_IDLE : uartrb_pkg::ST_BUSY;
                  end
                  if (prev_tx == uartrb_pkg::CMD_DONE_A && cur == uartrb_pkg::CMD_DONE_B)
                    hs_done = 1'b1;
                end
                rx_push(status);
                rx_push(uartrb_pkg::ST_IDLE);
                r.irq_pulse = 1'b1;
              end
              prev_tx = cur;
            end
          end
          uartrb_pkg::REG_IER: begin
            if (dlab) dlh_q = w.write_data;
            else ier_q = w.write_data;
          end
          uartrb_pkg::REG_IIR: fcr_q = w.write_data[7:0] & uartrb_pkg::FCR_MASK;
          uartrb_pkg::REG_LCR: lcr_q = w.write_data;
          uartrb_pkg::REG_MCR: mcr_q = w.write_data;
          uartrb_pkg::REG_SCR: scr_q = w.write_data;
          default: ;
        endcase
      end
      uartrb_pkg::OP_TICK: begin
        if (mode_q == uartrb_pkg::MODE_STREAM) begin
          if (ier_q[0]) begin
            // The accumulator saturates instead of wrapping.
            sum = {1'b0, accum} + w.tick_cycles;
            accum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (accum >= thresh_q) begin
              accum = '0;
              if (rx_count == 0) begin
                rx_push(uartrb_pkg::STREAM_B0);
                rx_push(uartrb_pkg::STREAM_B1);
                rx_push(uartrb_pkg::STREAM_B2);
              end
              r.irq_pulse = 1'b1;
            end
          end
        end else if (mode_q != uartrb_pkg::MODE_HANDSHAKE) begin
          // Modes 0 and 3 flush the receive FIFO on every tick.
          rx_head = 0;
          rx_count = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic uartrb_pkg::in_item_t make_word(logic [1:0] op, logic [11:0] off,
                                                     logic [15:0] wd, logic [15:0] cyc);
    uartrb_pkg::in_item_t w;
    w.opcode = op;
    w.reg_offset = off;
    w.write_data = wd;
    w.tick_cycles = cyc;
    return w;
  endfunction

  function automatic logic [11:0] pick_reg();
    case ($urandom_range(0, 7))
      0: return uartrb_pkg::REG_DATA;
      1: return uartrb_pkg::REG_IER;
      2: return uartrb_pkg::REG_IIR;
      3: return uartrb_pkg::REG_LCR;
      4: return uartrb_pkg::REG_MCR;
      5: return uartrb_pkg::REG_LSR;
      6: return REG_MSR;
      default: return uartrb_pkg::REG_SCR;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input uartrb_pkg::out_item_t want,
                               input uartrb_pkg::out_item_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s: expected read_data=%h irq_pulse=%b, got read_data=%h irq_pulse=%b",
               $realtime, what, want.read_data, want.irq_pulse, got.read_data, got.irq_pulse);
    end
  endtask

  // Configuration writes are only issued while the block has drained, so the
  // model can switch its copy immediately.
  task automatic cfg_write(input logic [uartrb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == uartrb_pkg::CFG_MODE) mode_q = val[1:0];
    else thresh_q = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] mode, input logic [15:0] thr,
                           input int src, input int snk);
    cfg_write(uartrb_pkg::CFG_MODE, {14'd0, mode});
    cfg_write(uartrb_pkg::CFG_THRESHOLD, thr);
    src_idle_pct = src;
    snk_stall_pct = snk;
  endtask

  // Returns once every queued word has gone in and every result has come out.
  task automatic wait_drain();
    while (access_queue.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random traffic. Most of it is register accesses that exercise the FIFO and
  // the responders: command pairs on THR, data pops, and ticks. A small share
  // is noise with any opcode and any offset.
  task automatic gen_random(input int n);
    int          added;
    int          pick;
    logic [7:0]  first;
    logic [7:0]  second;
    logic [15:0] val;
    logic [15:0] cyc;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(0, 99);
      val = 16'($urandom_range(0, 65535));
      if (pick < 8) begin
        // DLAB is mostly left clear so that THR and IER stay reachable.
        val[uartrb_pkg::DLAB_BIT] = ($urandom_range(0, 3) == 0);
        queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_LCR, val, '0));
      end else if (pick < 14) begin
        val[0] = ($urandom_range(0, 3) != 0);
        queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_IER, val, '0));
      end else if (pick < 24) begin
        queue_word(make_word(uartrb_pkg::OP_READ, pick_reg(), val, '0));
      end else if (pick < 42) begin
        queue_word(make_word(uartrb_pkg::OP_READ, uartrb_pkg::REG_DATA, '0, '0));
      end else if (pick < 56) begin
        case ($urandom_range(0, 2))
          0: cyc = 16'($urandom_range(0, 15));
          1: cyc = 16'($urandom_range(0, 511));
          default: cyc = 16'($urandom_range(0, 65535));
        endcase
        queue_word(make_word(uartrb_pkg::OP_TICK, '0, val, cyc));
      end else if (pick < 80) begin
        // A two-byte command, mostly one the responder knows.
        case ($urandom_range(0, 5))
          0: begin
            first = uartrb_pkg::CMD_RESET;
            second = uartrb_pkg::CMD_ZERO;
          end
          1: begin
            first = uartrb_pkg::CMD_QUERY;
            second = 8'($urandom_range(0, 255));
          end
          2, 3: begin
            first = uartrb_pkg::CMD_CALIB_A;
            second = uartrb_pkg::CMD_CALIB_B;
          end
          4: begin
            first = uartrb_pkg::CMD_DONE_A;
            second = uartrb_pkg::CMD_DONE_B;
          end
          default: begin
            first = 8'($urandom_range(0, 255));
            second = 8'($urandom_range(0, 255));
          end
        endcase
        if ($urandom_range(0, 4) == 0) second = 8'($urandom_range(0, 255));
        val[7:0] = first;
        queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_DATA, val, '0));
        val = 16'($urandom_range(0, 65535));
        val[7:0] = second;
        queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_DATA, val, '0));
        added++;
      end else if (pick < 92) begin
        queue_word(make_word(uartrb_pkg::OP_WRITE, pick_reg(), val, '0));
      end else begin
        queue_word(make_word(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                             val, 16'($urandom_range(0, 65535))));
      end
      added++;
    end
  endtask

  // Input driver: offers the next queued word at a falling edge, and holds it
  // until the rising edge at which it is accepted.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (access_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_valid <= 1'b1;
        in_item <= access_queue[0];
        access_queue.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Monitor: predicts on every accepted input word, checks every accepted
  // result word, and runs the watchdog. Inputs are handled before outputs so
  // the order of the two channels within one edge does not matter.
  always @(posedge clk) begin : monitor
    uartrb_pkg::out_item_t want;
    in_fire <= rst_n && in_valid && in_ready;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_replies = {expected_replies, predict_register_access(in_item)};
      end
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          note_mismatch("unexpected result", '0, out_item);
        end else begin
          want = expected_replies[0];
          expected_replies.delete(0);
          if (want.read_data !== out_item.read_data || want.irq_pulse !== out_item.irq_pulse)
            note_mismatch("result mismatch", want, out_item);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values and the plain register file, responder off (mode 0).
    // Covers an empty data read, the divisor latches behind DLAB, an FCR write
    // through the IIR offset, a THR write outside mode 1, the unknown opcode
    // and a tick that flushes the FIFO.
    queue_word(make_word(uartrb_pkg::OP_READ, uartrb_pkg::REG_LSR, '0, '0));
    queue_word(make_word(uartrb_pkg::OP_READ, uartrb_pkg::REG_IIR, '0, '0));
    queue_word(make_word(uartrb_pkg::OP_READ, uartrb_pkg::REG_DATA, '0, '0));
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_LCR, 16'h0080, '0));
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_DATA, 16'hFFFF, '0));
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_IER, 16'hFFFF, '0));
    queue_word(make_word(uartrb_pkg::OP_READ, uartrb_pkg::REG_DATA, '0, '0));
    queue_word(make_word(uartrb_pkg::OP_READ, uartrb_pkg::REG_IER, '0, '0));
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_LCR, 16'h0003, '0));
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_DATA, 16'h0020, '0));
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_IIR, 16'hFFFF, '0));
    queue_word(make_word(OP_NONE, 12'hFFF, 16'hFFFF, 16'hFFFF));
    queue_word(make_word(uartrb_pkg::OP_TICK, '0, '0, 16'hFFFF));
    gen_random(40);
    wait_drain();

    // Handshake responder. Reset, calibration, done and a query after done,
    // then a tick that must do nothing in this mode. The random part is left
    // to fill the FIFO, and the long receiver hold-off backs the block up.
    configure(uartrb_pkg::MODE_HANDSHAKE, 16'hFFFF, 0, 0);
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_DATA,
                         {8'h00, uartrb_pkg::CMD_RESET}, '0));
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_DATA,
                         {8'hFF, uartrb_pkg::CMD_ZERO}, '0));
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_DATA,
                         {8'h00, uartrb_pkg::CMD_CALIB_A}, '0));
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_DATA,
                         {8'h00, uartrb_pkg::CMD_CALIB_B}, '0));
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_DATA,
                         {8'h00, uartrb_pkg::CMD_DONE_A}, '0));
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_DATA,
                         {8'h00, uartrb_pkg::CMD_DONE_B}, '0));
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_DATA,
                         {8'h00, uartrb_pkg::CMD_QUERY}, '0));
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_DATA,
                         {8'h00, uartrb_pkg::CMD_ZERO}, '0));
    queue_word(make_word(uartrb_pkg::OP_TICK, '0, '0, 16'hFFFF));
    queue_word(make_word(uartrb_pkg::OP_READ, uartrb_pkg::REG_DATA, '0, '0));
    queue_word(make_word(uartrb_pkg::OP_READ, uartrb_pkg::REG_LSR, '0, '0));
    gen_random(60);
    hold_req = 1'b1;
    wait_drain();

    // Streamer with a zero threshold: a tick with IER bit 0 clear does nothing,
    // then every enabled tick fires, even one of zero cycles.
    configure(uartrb_pkg::MODE_STREAM, 16'h0000, 45, 0);
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_IER, 16'h0000, '0));
    queue_word(make_word(uartrb_pkg::OP_TICK, '0, '0, 16'h0010));
    queue_word(make_word(uartrb_pkg::OP_WRITE, uartrb_pkg::REG_IER, 16'h0001, '0));
    queue_word(make_word(uartrb_pkg::OP_TICK, '0, '0, 16'h0000));
    queue_word(make_word(uartrb_pkg::OP_READ, uartrb_pkg::REG_DATA, '0, '0));
    queue_word(make_word(uartrb_pkg::OP_READ, uartrb_pkg::REG_DATA, '0, '0));
    queue_word(make_word(uartrb_pkg::OP_READ, uartrb_pkg::REG_DATA, '0, '0));
    queue_word(make_word(uartrb_pkg::OP_READ, uartrb_pkg::REG_LSR, '0, '0));
    gen_random(50);
    wait_drain();

    configure(uartrb_pkg::MODE_STREAM, 16'h0001, 0, 45);
    gen_random(50);
    wait_drain();

    configure(uartrb_pkg::MODE_STREAM, 16'($urandom_range(2, 400)), 35, 35);
    gen_random(50);
    wait_drain();

    configure(uartrb_pkg::MODE_HANDSHAKE, uartrb_pkg::THRESHOLD_RESET, 45, 0);
    gen_random(50);
    wait_drain();

    // Mode 3 must behave as mode 0.
    configure(MODE_NONE_ALT, 16'hFFFF, 0, 45);
    gen_random(40);
    wait_drain();

    configure(uartrb_pkg::MODE_STREAM, 16'hFFFF, 35, 35);
    gen_random(40);
    wait_drain();

    configure(uartrb_pkg::MODE_NONE, uartrb_pkg::THRESHOLD_RESET, 0, 0);
    gen_random(20);
    wait_drain();

    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
